>>> hw/rtl/olph_pkg.sv
`default_nettype none
package olph_pkg;

    localparam int MAX_BUCKETS_DEF = 1024;
    localparam int OVERFLOW_SLOTS_DEF = 256;
    localparam int BCNT_W = 11;
    localparam int DATA_W = 32;
    localparam logic [BCNT_W-1:0] BCNT_RESET = 11'd1021;
    localparam logic [BCNT_W-1:0] BCNT_MIN = 11'd2;

    typedef enum logic [1:0] {
        K_GET    = 2'd0,
        K_INSERT = 2'd1,
        K_REMOVE = 2'd2,
        K_SET    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_EMPTY = 2'd0,
        ST_FULL  = 2'd1,
        ST_TOMB  = 2'd2
    } t_slot_st;

    typedef enum logic [1:0] {
        OC_DONE    = 2'd0,
        OC_MISSING = 2'd1,
        OC_DUP     = 2'd2,
        OC_NOSLOT  = 2'd3
    } t_outcome;

    typedef struct packed {
        logic     clr_step;
        logic     load;
        logic     mod_key_start;
        logic     mod_slot_start;
        logic     set_h0;
        logic     h_reset;
        logic     h_inc;
        logic     rd_h;
        logic     e_init;
        logic     e_inc;
        logic     rd_e;
        logic     rd_em1;
        logic     wr_move;
        logic     wr_place;
        logic     wr_tomb;
        logic     wr_value;
        logic     res_load;
        logic     res_found;
        t_outcome res_oc;
    } t_cmd;

    typedef struct packed {
        logic        clr_last;
        logic        mod_done;
        logic        home_gt;
        logic        home_ge;
        logic [1:0]  slot_st;
        logic        key_match;
        logic        h_last;
        logic        h_next_ge_b;
        logic        e_last;
        logic        e_next_h;
        logic        table_full;
        t_kind       kind;
        logic        out_free;
    } t_sts;

endpackage
`default_nettype wire

>>> hw/rtl/olph_mod.sv
`default_nettype none
module olph_mod (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic signed [olph_pkg::DATA_W-1:0] i_dividend,
    input  logic [olph_pkg::BCNT_W-1:0]     i_div,
    output logic                            o_done,
    output logic [olph_pkg::BCNT_W-1:0]     o_rem
);
    import olph_pkg::*;

    localparam int StepsPerCycle = 4;
    localparam int CntW = $clog2(DATA_W / StepsPerCycle);
    localparam logic [CntW-1:0] CntLast = CntW'(DATA_W / StepsPerCycle - 1);

    logic                r_busy;
    logic                r_done;
    logic [CntW-1:0]     r_cnt;
    logic [DATA_W-1:0]   r_num;
    logic [BCNT_W:0]     r_rem;
    logic                r_neg;
    logic [DATA_W-1:0]   w_abs;
    logic [DATA_W-1:0]   n_num;
    logic [BCNT_W:0]     n_rem;

    assign w_abs = i_dividend[DATA_W-1] ? (~i_dividend + 32'd1) : i_dividend;

    always_comb begin
        n_rem = r_rem;
        n_num = r_num;
        for (int j = 0; j < StepsPerCycle; j++) begin
            n_rem = {n_rem[BCNT_W-1:0], n_num[DATA_W-1]};
            n_num = {n_num[DATA_W-2:0], 1'b0};
            if (n_rem >= {1'b0, i_div}) begin
                n_rem = n_rem - {1'b0, i_div};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CntW'(1);
                if (r_cnt == CntLast) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= w_abs;
            r_rem <= '0;
            r_neg <= i_dividend[DATA_W-1];
        end else if (r_busy) begin
            r_num <= n_num;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = (r_neg && (r_rem != '0)) ? (i_div - r_rem[BCNT_W-1:0])
                                             : r_rem[BCNT_W-1:0];

    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> !r_busy)
        else $error("modulo unit restarted while busy");

endmodule
`default_nettype wire

>>> hw/rtl/olph_dp.sv
`default_nettype none
module olph_dp #(
    parameter int MAX_BUCKETS    = olph_pkg::MAX_BUCKETS_DEF,
    parameter int OVERFLOW_SLOTS = olph_pkg::OVERFLOW_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  olph_pkg::t_cmd                     i_cmd,
    output olph_pkg::t_sts                     o_sts,
    input  logic [1:0]                         i_kind,
    input  logic signed [olph_pkg::DATA_W-1:0] i_key,
    input  logic signed [olph_pkg::DATA_W-1:0] i_value,
    input  logic                               i_cfg_valid,
    input  logic [olph_pkg::BCNT_W-1:0]        i_cfg_bucket_count,
    input  logic                               i_out_ready,
    output logic                               o_out_valid,
    output logic                               o_ok,
    output logic signed [olph_pkg::DATA_W-1:0] o_found_value,
    output logic [1:0]                         o_outcome
);
    import olph_pkg::*;

    localparam int SlotTotal = MAX_BUCKETS + OVERFLOW_SLOTS;
    localparam int IW = $clog2(SlotTotal);
    localparam int CW = (IW > BCNT_W) ? IW : BCNT_W;
    localparam logic [IW-1:0] LastIdx = IW'(SlotTotal - 1);

    logic [1:0]         m_st  [SlotTotal];
    logic [DATA_W-1:0]  m_key [SlotTotal];
    logic [DATA_W-1:0]  m_val [SlotTotal];

    logic [BCNT_W-1:0]  r_bcnt;
    logic [BCNT_W-1:0]  r_count;
    logic [IW-1:0]      r_clr;
    logic               r_out_valid;
    t_kind              r_kind;
    logic [DATA_W-1:0]  r_key;
    logic [DATA_W-1:0]  r_value;
    logic [BCNT_W-1:0]  r_h0;
    logic [IW-1:0]      r_h;
    logic [IW-1:0]      r_e;
    logic [1:0]         r_rd_st;
    logic [DATA_W-1:0]  r_rd_key;
    logic [DATA_W-1:0]  r_rd_value;
    logic               r_ok;
    logic [DATA_W-1:0]  r_found;
    t_outcome           r_oc;

    logic [BCNT_W-1:0]  w_b;
    logic [BCNT_W-1:0]  w_home;
    logic               w_mod_done;
    logic [IW-1:0]      w_ra;
    logic [IW-1:0]      w_wa;
    logic               w_rd_en;
    logic               w_st_we;
    logic [1:0]         w_st_wd;
    logic [IW-1:0]      w_em1;

    always_comb begin
        if (r_bcnt < BCNT_MIN) begin
            w_b = BCNT_MIN;
        end else if (32'(r_bcnt) > MAX_BUCKETS) begin
            w_b = BCNT_W'(MAX_BUCKETS);
        end else begin
            w_b = r_bcnt;
        end
    end

    olph_mod u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.mod_key_start | i_cmd.mod_slot_start),
        .i_dividend (i_cmd.mod_key_start ? i_key : signed'(r_rd_key)),
        .i_div      (w_b),
        .o_done     (w_mod_done),
        .o_rem      (w_home)
    );

    assign w_em1   = r_e - IW'(1);
    assign w_rd_en = i_cmd.rd_h | i_cmd.rd_e | i_cmd.rd_em1;

    always_comb begin
        priority if (i_cmd.rd_e) begin
            w_ra = r_e;
        end else if (i_cmd.rd_em1) begin
            w_ra = w_em1;
        end else begin
            w_ra = r_h;
        end
    end

    always_comb begin
        priority if (i_cmd.clr_step) begin
            w_wa = r_clr;
        end else if (i_cmd.wr_move) begin
            w_wa = r_e;
        end else begin
            w_wa = r_h;
        end
    end

    assign w_st_we = i_cmd.clr_step | i_cmd.wr_move | i_cmd.wr_place | i_cmd.wr_tomb;

    always_comb begin
        priority if (i_cmd.clr_step) begin
            w_st_wd = ST_EMPTY;
        end else if (i_cmd.wr_move) begin
            w_st_wd = r_rd_st;
        end else if (i_cmd.wr_place) begin
            w_st_wd = ST_FULL;
        end else begin
            w_st_wd = ST_TOMB;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_st_we) begin
            m_st[w_wa] <= w_st_wd;
        end
        if (w_rd_en) begin
            r_rd_st <= m_st[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_move) begin
            m_key[w_wa] <= r_rd_key;
        end else if (i_cmd.wr_place) begin
            m_key[w_wa] <= r_key;
        end
        if (w_rd_en) begin
            r_rd_key <= m_key[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_move) begin
            m_val[w_wa] <= r_rd_value;
        end else if (i_cmd.wr_place || i_cmd.wr_value) begin
            m_val[w_wa] <= r_value;
        end
        if (w_rd_en) begin
            r_rd_value <= m_val[w_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt      <= BCNT_RESET;
            r_count     <= '0;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_bcnt <= i_cfg_bucket_count;
            end
            if (i_cmd.clr_step) begin
                r_clr <= r_clr + IW'(1);
            end
            if (i_cmd.wr_place) begin
                r_count <= r_count + BCNT_W'(1);
            end else if (i_cmd.wr_tomb && (r_count != '0)) begin
                r_count <= r_count - BCNT_W'(1);
            end
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind  <= t_kind'(i_kind);
            r_key   <= i_key;
            r_value <= i_value;
        end
        if (i_cmd.set_h0) begin
            r_h0 <= w_home;
            r_h  <= IW'(w_home);
        end else if (i_cmd.h_reset) begin
            r_h <= IW'(r_h0);
        end else if (i_cmd.h_inc) begin
            r_h <= r_h + IW'(1);
        end
        if (i_cmd.e_init) begin
            r_e <= r_h + IW'(1);
        end else if (i_cmd.e_inc) begin
            r_e <= r_e + IW'(1);
        end else if (i_cmd.wr_move) begin
            r_e <= w_em1;
        end
        if (i_cmd.res_load) begin
            r_ok    <= (i_cmd.res_oc == OC_DONE);
            r_found <= i_cmd.res_found ? r_rd_value : '0;
            r_oc    <= i_cmd.res_oc;
        end
    end

    always_comb begin
        o_sts.clr_last    = (r_clr == LastIdx);
        o_sts.mod_done    = w_mod_done;
        o_sts.home_gt     = (w_home > r_h0);
        o_sts.home_ge     = (w_home >= r_h0);
        o_sts.slot_st     = r_rd_st;
        o_sts.key_match   = (r_rd_key == r_key);
        o_sts.h_last      = (r_h == LastIdx);
        o_sts.h_next_ge_b = ((CW+1)'(r_h) + (CW+1)'(1)) >= (CW+1)'(w_b);
        o_sts.e_last      = (r_e == LastIdx);
        o_sts.e_next_h    = (w_em1 == r_h);
        o_sts.table_full  = (r_count >= w_b);
        o_sts.kind        = r_kind;
        o_sts.out_free    = !r_out_valid || i_out_ready;
    end

    assign o_out_valid   = r_out_valid;
    assign o_ok          = r_ok;
    assign o_found_value = r_found;
    assign o_outcome     = r_oc;

    a_place_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_place |=> (r_count == $past(r_count) + BCNT_W'(1)))
        else $error("entry count not advanced by a placement");

    a_move_above: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.wr_move |-> (r_e != r_h))
        else $error("run shift reached the insertion slot");

endmodule
`default_nettype wire

>>> hw/rtl/olph_ctrl.sv
`default_nettype none
module olph_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  olph_pkg::t_sts i_sts,
    output olph_pkg::t_cmd o_cmd
);
    import olph_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR = 15'h0001,
        S_IDLE  = 15'h0002,
        S_HOME  = 15'h0004,
        S_LRD   = 15'h0008,
        S_LCHK  = 15'h0010,
        S_LMOD  = 15'h0020,
        S_IRD   = 15'h0040,
        S_ICHK  = 15'h0080,
        S_IMOD  = 15'h0100,
        S_SRD   = 15'h0200,
        S_SCHK  = 15'h0400,
        S_MRD   = 15'h0800,
        S_MWR   = 15'h1000,
        S_PLACE = 15'h2000,
        S_RES   = 15'h4000
    } t_state;

    t_state   r_state;
    t_state   n_state;
    t_outcome r_oc;
    t_outcome n_oc;
    logic     r_found;
    logic     n_found;

    always_comb begin
        n_state = r_state;
        n_oc    = r_oc;
        n_found = r_found;
        o_cmd   = '0;
        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr_step = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load          = 1'b1;
                    o_cmd.mod_key_start = 1'b1;
                    n_found             = 1'b0;
                    n_oc                = OC_DONE;
                    n_state             = S_HOME;
                end
            end
            S_HOME: begin
                if (i_sts.mod_done) begin
                    o_cmd.set_h0 = 1'b1;
                    if (i_sts.kind != K_INSERT) begin
                        n_state = S_LRD;
                    end else if (i_sts.table_full) begin
                        n_oc    = OC_NOSLOT;
                        n_state = S_RES;
                    end else begin
                        n_state = S_IRD;
                    end
                end
            end
            S_LRD: begin
                o_cmd.rd_h = 1'b1;
                n_state    = S_LCHK;
            end
            S_LCHK, S_LMOD: begin
                if ((r_state == S_LCHK) && (i_sts.slot_st == ST_FULL) && i_sts.key_match) begin
                    unique case (i_sts.kind)
                        K_GET:    n_found        = 1'b1;
                        K_REMOVE: o_cmd.wr_tomb  = 1'b1;
                        K_SET:    o_cmd.wr_value = 1'b1;
                        default:  n_found        = 1'b0;
                    endcase
                    n_oc    = OC_DONE;
                    n_state = S_RES;
                end else if ((r_state == S_LCHK) && (i_sts.slot_st != ST_EMPTY)) begin
                    o_cmd.mod_slot_start = 1'b1;
                    n_state              = S_LMOD;
                end else if ((r_state == S_LMOD) && !i_sts.mod_done) begin
                    n_state = S_LMOD;
                end else if ((r_state == S_LMOD) && !i_sts.home_gt && !i_sts.h_last) begin
                    o_cmd.h_inc = 1'b1;
                    n_state     = S_LRD;
                end else if (i_sts.kind != K_SET) begin
                    n_oc    = OC_MISSING;
                    n_state = S_RES;
                end else if (i_sts.table_full) begin
                    n_oc    = OC_NOSLOT;
                    n_state = S_RES;
                end else begin
                    o_cmd.h_reset = 1'b1;
                    n_state       = S_IRD;
                end
            end
            S_IRD: begin
                o_cmd.rd_h = 1'b1;
                n_state    = S_ICHK;
            end
            S_ICHK: begin
                if (i_sts.slot_st == ST_EMPTY) begin
                    n_state = S_PLACE;
                end else if ((i_sts.slot_st == ST_FULL) && i_sts.key_match) begin
                    n_oc    = OC_DUP;
                    n_state = S_RES;
                end else begin
                    o_cmd.mod_slot_start = 1'b1;
                    n_state              = S_IMOD;
                end
            end
            S_IMOD: begin
                if (i_sts.mod_done) begin
                    if ((i_sts.slot_st == ST_TOMB) && i_sts.home_ge) begin
                        n_state = S_PLACE;
                    end else if (i_sts.home_gt) begin
                        o_cmd.e_init = 1'b1;
                        n_state      = S_SRD;
                    end else if (i_sts.h_next_ge_b) begin
                        n_oc    = OC_NOSLOT;
                        n_state = S_RES;
                    end else begin
                        o_cmd.h_inc = 1'b1;
                        n_state     = S_IRD;
                    end
                end
            end
            S_SRD: begin
                o_cmd.rd_e = 1'b1;
                n_state    = S_SCHK;
            end
            S_SCHK: begin
                if (i_sts.slot_st != ST_FULL) begin
                    n_state = S_MRD;
                end else if (i_sts.e_last) begin
                    n_oc    = OC_NOSLOT;
                    n_state = S_RES;
                end else begin
                    o_cmd.e_inc = 1'b1;
                    n_state     = S_SRD;
                end
            end
            S_MRD: begin
                o_cmd.rd_em1 = 1'b1;
                n_state      = S_MWR;
            end
            S_MWR: begin
                o_cmd.wr_move = 1'b1;
                n_state       = i_sts.e_next_h ? S_PLACE : S_MRD;
            end
            S_PLACE: begin
                o_cmd.wr_place = 1'b1;
                n_oc           = OC_DONE;
                n_state        = S_RES;
            end
            S_RES: begin
                if (i_sts.out_free) begin
                    o_cmd.res_load  = 1'b1;
                    o_cmd.res_found = r_found;
                    o_cmd.res_oc    = r_oc;
                    n_state         = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_oc    <= OC_DONE;
            r_found <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oc    <= n_oc;
            r_found <= n_found;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    a_res_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.res_load |-> i_sts.out_free)
        else $error("result loaded over an untaken result");

    a_found_get: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.res_load && o_cmd.res_found) |-> (i_sts.kind == K_GET && r_oc == OC_DONE))
        else $error("found value on a result that is not a successful get");

endmodule
`default_nettype wire

>>> hw/rtl/ordered_linear_probe_hash_table.sv
`default_nettype none
// Channel   Direction  Handshake                      Payload
// request   in         i_in_valid / o_in_ready        i_kind, i_key, i_value
// result    out        o_out_valid / i_out_ready      o_ok, o_found_value, o_outcome
// config    in         i_cfg_valid / o_cfg_ready      i_cfg_bucket_count
//
// After reset the slot status memory is swept to empty, one slot a cycle, over all
// MAX_BUCKETS + OVERFLOW_SLOTS slots, before the first request is taken.
// A request computes the key's home with the 4-bit-per-cycle modulo unit, then reads
// slots from the home; each slot that is neither empty nor holding the key has its
// own home computed by the same unit. An insert that shifts a run scans up to the
// first slot that is not full and then moves each entry of the run one slot up.
// One request is in flight at a time; a new request is taken while a result waits.
module ordered_linear_probe_hash_table #(
    parameter int MAX_BUCKETS    = olph_pkg::MAX_BUCKETS_DEF,
    parameter int OVERFLOW_SLOTS = olph_pkg::OVERFLOW_SLOTS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  logic [1:0]                         i_kind,
    input  logic signed [olph_pkg::DATA_W-1:0] i_key,
    input  logic signed [olph_pkg::DATA_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic                               o_ok,
    output logic signed [olph_pkg::DATA_W-1:0] o_found_value,
    output logic [1:0]                         o_outcome,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [olph_pkg::BCNT_W-1:0]        i_cfg_bucket_count
);
    import olph_pkg::*;

    t_cmd w_cmd;
    t_sts w_sts;

    assign o_cfg_ready = 1'b1;

    olph_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    olph_dp #(
        .MAX_BUCKETS    (MAX_BUCKETS),
        .OVERFLOW_SLOTS (OVERFLOW_SLOTS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_sts              (w_sts),
        .i_kind             (i_kind),
        .i_key              (i_key),
        .i_value            (i_value),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_bucket_count (i_cfg_bucket_count),
        .i_out_ready        (i_out_ready),
        .o_out_valid        (o_out_valid),
        .o_ok               (o_ok),
        .o_found_value      (o_found_value),
        .o_outcome          (o_outcome)
    );

endmodule
`default_nettype wire
